@@ rtl/core/image_mirror_dedup_core_defines.svh @@
// assertion macros for the image mirror dedup core
// depends on nothing; users must have signals named clock and reset in scope
`ifndef IMAGE_MIRROR_DEDUP_CORE_DEFINES_SVH
`define IMAGE_MIRROR_DEDUP_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define IMD_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("imd assertion failed");
`define IMD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("imd assertion failed");
`else
`define IMD_ASSERT_NOW(label, ante, cons)
`define IMD_ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ rtl/core/imd_pkg.sv @@
// shared constants, codes, types and the reflection address function
// used by every module of the image mirror dedup core
package imd_pkg;

   localparam int MAX_SIDE = 64;
   localparam int SIDE_W   = $clog2(MAX_SIDE);
   localparam int ADDR_W   = 2 * SIDE_W;
   localparam int DEPTH    = MAX_SIDE * MAX_SIDE;
   localparam int PIX_W    = 8;
   localparam int CFG_W    = 7;
   localparam int COUNT_W  = 3;
   localparam int SLOTS    = 4;

   localparam logic [1:0] ACT_WRITE = 2'd0;
   localparam logic [1:0] ACT_EVAL  = 2'd1;
   localparam logic [1:0] ACT_READ  = 2'd2;

   localparam logic [1:0] T_HORIZ = 2'd0;
   localparam logic [1:0] T_VERT  = 2'd1;
   localparam logic [1:0] T_ANTI  = 2'd2;
   localparam logic [1:0] T_TRANS = 2'd3;

   localparam logic CSR_SIDE = 1'b0;
   localparam logic CSR_DIAG = 1'b1;

   typedef struct packed {
      logic [SLOTS-1:0][1:0] codes;
      logic [COUNT_W-1:0]    total;
      logic                  done;
   } imd_eval_status_type;

   // store address of pixel (i,j) of reflection code, side-1 = nm1
   function automatic logic [ADDR_W-1:0] reflect_addr(
      input logic [1:0]        code,
      input logic [SIDE_W-1:0] nm1,
      input logic [SIDE_W-1:0] i,
      input logic [SIDE_W-1:0] j
   );
      logic [SIDE_W-1:0] r;
      logic [SIDE_W-1:0] c;
      unique case (code)
         T_HORIZ: begin
            r = i;
            c = nm1 - j;
         end
         T_VERT: begin
            r = nm1 - i;
            c = j;
         end
         T_ANTI: begin
            r = nm1 - j;
            c = nm1 - i;
         end
         T_TRANS: begin
            r = j;
            c = i;
         end
      endcase
      return {r, c};
   endfunction

endpackage

@@ rtl/core/imd_store.sv @@
// pixel store: one write port, one read port with registered read data
// depends on imd_pkg
module imd_store (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [imd_pkg::ADDR_W-1:0] wr_addr,
   input  logic [imd_pkg::PIX_W-1:0]  wr_data,
   input  logic [imd_pkg::ADDR_W-1:0] rd_addr,
   output logic [imd_pkg::PIX_W-1:0]  rd_data
);
   import imd_pkg::*;

   logic [PIX_W-1:0] mem_ff [DEPTH];
   logic [PIX_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/imd_eval.sv @@
// evaluate sequencer: walks pixel pairs through the store read port and
// one comparator, keeps the list of distinct reflections; depends on imd_pkg
module imd_eval (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic                                 with_diag,
   input  logic [imd_pkg::SIDE_W-1:0]           nm1,
   input  logic [imd_pkg::PIX_W-1:0]            rd_data,
   output logic [imd_pkg::ADDR_W-1:0]           rd_addr,
   output imd_pkg::imd_eval_status_type         status
);
   import imd_pkg::*;

   localparam logic [1:0] E_IDLE = 2'd0;
   localparam logic [1:0] E_RDA  = 2'd1;
   localparam logic [1:0] E_RDB  = 2'd2;
   localparam logic [1:0] E_CMP  = 2'd3;

   logic [1:0]             state_ff, state_in;
   logic [1:0]             cand_ff, cand_in;
   logic [1:0]             k_ff, k_in;
   logic [SIDE_W-1:0]      i_ff, i_in;
   logic [SIDE_W-1:0]      j_ff, j_in;
   logic [PIX_W-1:0]       a_ff, a_in;
   logic [SLOTS-1:0][1:0]  codes_ff, codes_in;
   logic [COUNT_W-1:0]     total_ff, total_in;
   logic                   done_ff, done_in;
   logic                   next_cand;
   logic                   last_pix;

   always_comb begin
      state_in  = state_ff;
      cand_in   = cand_ff;
      k_in      = k_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      a_in      = a_ff;
      codes_in  = codes_ff;
      total_in  = total_ff;
      done_in   = 1'b0;
      next_cand = 1'b0;
      last_pix  = (i_ff == nm1) && (j_ff == nm1);
      unique case (state_ff)
         E_IDLE: begin
            if (start) begin
               codes_in = '0;
               total_in = COUNT_W'(1);
               cand_in  = T_VERT;
               k_in     = '0;
               i_in     = '0;
               j_in     = '0;
               state_in = E_RDA;
            end
         end
         E_RDA: begin
            state_in = E_RDB;
         end
         E_RDB: begin
            a_in     = rd_data;
            state_in = E_CMP;
         end
         E_CMP: begin
            if (rd_data != a_ff) begin
               // differs from this kept one: try the next kept, else keep it
               if (({1'b0, k_ff} + 3'd1) < total_ff) begin
                  k_in     = k_ff + 2'd1;
                  i_in     = '0;
                  j_in     = '0;
                  state_in = E_RDA;
               end else begin
                  codes_in[total_ff[1:0]] = cand_ff;
                  total_in  = total_ff + COUNT_W'(1);
                  next_cand = 1'b1;
               end
            end else if (last_pix) begin
               next_cand = 1'b1;
            end else begin
               if (j_ff == nm1) begin
                  j_in = '0;
                  i_in = i_ff + SIDE_W'(1);
               end else begin
                  j_in = j_ff + SIDE_W'(1);
               end
               state_in = E_RDA;
            end
            if (next_cand) begin
               k_in = '0;
               i_in = '0;
               j_in = '0;
               priority if ((cand_ff == T_VERT) && with_diag) begin
                  cand_in  = T_ANTI;
                  state_in = E_RDA;
               end else if (cand_ff == T_ANTI) begin
                  cand_in  = T_TRANS;
                  state_in = E_RDA;
               end else begin
                  state_in = E_IDLE;
                  done_in  = 1'b1;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= E_IDLE;
         codes_ff <= '0;
         total_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         codes_ff <= codes_in;
         total_ff <= total_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cand_ff <= cand_in;
      k_ff    <= k_in;
      i_ff    <= i_in;
      j_ff    <= j_in;
      a_ff    <= a_in;
   end

   assign rd_addr = (state_ff == E_RDA) ? reflect_addr(codes_ff[k_ff], nm1, i_ff, j_ff)
                                        : reflect_addr(cand_ff, nm1, i_ff, j_ff);

   assign status.codes = codes_ff;
   assign status.total = total_ff;
   assign status.done  = done_ff;

endmodule

@@ rtl/core/image_mirror_dedup_core.sv @@
// top level of the image mirror dedup core: command channel, config registers,
// read path; depends on imd_pkg, imd_store, imd_eval and the defines header
//
// Usage: a command beat is taken at a rising edge with start high and busy low.
// req_action selects write pixel, evaluate or read reflected pixel; every
// command gives exactly one response beat, marked by rsp_valid for one cycle.
// The receiver cannot stall, so rsp_valid is never held.
// Latency and throughput:
//   write and unused action: response the cycle after the command, a new
//     command every cycle
//   read: store address, registered store data, then the response register;
//     busy stays high until the response
//   evaluate: each image compare reads every pixel pair in turn through the
//     single store read port and comparator, at most 6 compares of side*side
//     pixels; busy stays high until the response
// Config writes (csr_index 0 side, 1 with_diagonals) are taken on any cycle
// with csr_valid, and must only come while the core is idle.
// Reset: side 1, diagonals off, no reflections kept; pixel store is not
// cleared and must be written before it is read.
module image_mirror_dedup_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [1:0]                  req_action,
   input  logic [imd_pkg::SIDE_W-1:0]  req_row,
   input  logic [imd_pkg::SIDE_W-1:0]  req_col,
   input  logic [imd_pkg::PIX_W-1:0]   req_pixel,
   input  logic [1:0]                  req_image_index,
   output logic                        rsp_valid,
   output logic [imd_pkg::COUNT_W-1:0] rsp_kept_count,
   output logic [imd_pkg::PIX_W-1:0]   rsp_pixel_out,
   output logic                        rsp_image_valid,
   output logic [1:0]                  rsp_transform_code,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic                        csr_index,
   input  logic [imd_pkg::CFG_W-1:0]   csr_wdata
);
   import imd_pkg::*;
`include "image_mirror_dedup_core_defines.svh"

   localparam logic [1:0] S_IDLE    = 2'd0;
   localparam logic [1:0] S_EVAL    = 2'd1;
   localparam logic [1:0] S_RD_ADDR = 2'd2;
   localparam logic [1:0] S_RD_DATA = 2'd3;

   logic [1:0]          state_ff, state_in;
   logic [CFG_W-1:0]    side_ff;
   logic                diag_ff;
   logic [SIDE_W-1:0]   row_ff, row_in;
   logic [SIDE_W-1:0]   col_ff, col_in;
   logic [1:0]          slot_ff, slot_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0]  rsp_count_ff, rsp_count_in;
   logic [PIX_W-1:0]    rsp_pixel_ff, rsp_pixel_in;
   logic                rsp_ivalid_ff, rsp_ivalid_in;
   logic [1:0]          rsp_code_ff, rsp_code_in;

   logic                accept;
   logic [CFG_W-1:0]    side_m1;
   logic [SIDE_W-1:0]   nm1;
   logic [ADDR_W-1:0]   read_addr;
   logic [ADDR_W-1:0]   eval_addr;
   logic [ADDR_W-1:0]   mem_raddr;
   logic [PIX_W-1:0]    mem_rdata;
   logic                slot_ok;
   logic                in_image;
   imd_eval_status_type eval_stat;

   assign accept    = start && !busy;
   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;

   // side 0 acts as 1, side above the store acts as the store side
   always_comb begin
      priority if (side_ff == '0) begin
         side_m1 = '0;
      end else if (side_ff > CFG_W'(MAX_SIDE)) begin
         side_m1 = CFG_W'(MAX_SIDE - 1);
      end else begin
         side_m1 = side_ff - CFG_W'(1);
      end
   end
   assign nm1 = side_m1[SIDE_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff <= CFG_W'(1);
         diag_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SIDE: side_ff <= csr_wdata;
            CSR_DIAG: diag_ff <= csr_wdata[0];
         endcase
      end
   end

   assign read_addr = reflect_addr(eval_stat.codes[slot_ff], nm1, row_ff, col_ff);
   assign mem_raddr = (state_ff == S_EVAL) ? eval_addr : read_addr;

   imd_store u_store (
      .clock   (clock),
      .wr_en   (accept && (req_action == ACT_WRITE)),
      .wr_addr ({req_row, req_col}),
      .wr_data (req_pixel),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   imd_eval u_eval (
      .clock     (clock),
      .reset     (reset),
      .start     (accept && (req_action == ACT_EVAL)),
      .with_diag (diag_ff),
      .nm1       (nm1),
      .rd_data   (mem_rdata),
      .rd_addr   (eval_addr),
      .status    (eval_stat)
   );

   assign slot_ok  = ({1'b0, slot_ff} < eval_stat.total);
   assign in_image = (row_ff <= nm1) && (col_ff <= nm1);

   always_comb begin
      state_in      = state_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      slot_in       = slot_ff;
      rsp_valid_in  = 1'b0;
      rsp_count_in  = eval_stat.total;
      rsp_pixel_in  = '0;
      rsp_ivalid_in = 1'b0;
      rsp_code_in   = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               priority if (req_action == ACT_EVAL) begin
                  state_in = S_EVAL;
               end else if (req_action == ACT_READ) begin
                  row_in   = req_row;
                  col_in   = req_col;
                  slot_in  = req_image_index;
                  state_in = S_RD_ADDR;
               end else begin
                  rsp_valid_in = 1'b1;
               end
            end
         end
         S_EVAL: begin
            if (eval_stat.done) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_RD_ADDR: begin
            state_in = S_RD_DATA;
         end
         S_RD_DATA: begin
            rsp_valid_in  = 1'b1;
            rsp_ivalid_in = slot_ok;
            rsp_code_in   = slot_ok ? eval_stat.codes[slot_ff] : T_HORIZ;
            rsp_pixel_in  = (slot_ok && in_image) ? mem_rdata : '0;
            state_in      = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff  <= row_in;
      col_ff  <= col_in;
      slot_ff <= slot_in;
      if (rsp_valid_in) begin
         rsp_count_ff  <= rsp_count_in;
         rsp_pixel_ff  <= rsp_pixel_in;
         rsp_ivalid_ff <= rsp_ivalid_in;
         rsp_code_ff   <= rsp_code_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kept_count     = rsp_count_ff;
   assign rsp_pixel_out      = rsp_pixel_ff;
   assign rsp_image_valid    = rsp_ivalid_ff;
   assign rsp_transform_code = rsp_code_ff;

   // every accepted beat either answers next cycle or holds the core busy
   `IMD_ASSERT_NEXT(a_cmd_progress, accept, rsp_valid || busy)
   // evaluate finishes only while the top level waits for it
   `IMD_ASSERT_NOW(a_eval_done_owned, eval_stat.done, state_ff == S_EVAL)
   // a finished evaluate always keeps between one and four reflections
   `IMD_ASSERT_NOW(a_eval_total, eval_stat.done,
      (eval_stat.total != '0) && (eval_stat.total <= COUNT_W'(SLOTS)))
   // a read of an empty slot carries no pixel and no code
   `IMD_ASSERT_NOW(a_empty_slot, rsp_valid && !rsp_image_valid,
      (rsp_pixel_out == '0) && (rsp_transform_code == T_HORIZ))

endmodule
